// File: rtl/core/http_chunked_body_decoder_assert.svh
// Assertion macros used by the checker file.
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define HCBD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define HCBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/hcbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package hcbd_pkg;

	localparam int MAX_SIZE_DIGITS = 8;
	localparam int CNT_W           = $clog2(MAX_SIZE_DIGITS + 1);
	localparam int SIZE_W          = 32;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_SP  = 8'h20;
	localparam logic [7:0] CH_TAB = 8'h09;

	typedef enum logic [3:0] {
		PH_LEAD,
		PH_DIGITS,
		PH_TAIL,
		PH_TAIL_CR,
		PH_DATA,
		PH_WANT_CR,
		PH_WANT_LF,
		PH_ENDED,
		PH_PASS
	} phase_t;

	typedef struct packed {
		logic [7:0] data;
		logic       valid;
		logic       ended;
		logic       fault;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/hcbd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_parser (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             mode,
	input  wire logic [7:0]       byte_s1,
	output hcbd_pkg::result_t     res
);

	hcbd_pkg::phase_t                  phase_q, phase_d;
	logic [hcbd_pkg::SIZE_W-1:0]       left_q, left_d;
	logic [hcbd_pkg::CNT_W-1:0]        count_q, count_d;

	logic                              is_hex, is_blank;
	logic [3:0]                        nib;
	logic                              valid, ended, fault;
	logic [hcbd_pkg::SIZE_W+3:0]       acc_wide;
	logic [hcbd_pkg::SIZE_W-1:0]       acc_sat;

	// byte classification
	always_comb begin
		is_hex = 1'b1;
		nib    = 4'd0;
		if (byte_s1 >= 8'h30 && byte_s1 <= 8'h39) begin
			nib = 4'(byte_s1 - 8'h30);
		end else if (byte_s1 >= 8'h61 && byte_s1 <= 8'h66) begin
			nib = 4'(byte_s1 - 8'h57);
		end else if (byte_s1 >= 8'h41 && byte_s1 <= 8'h46) begin
			nib = 4'(byte_s1 - 8'h37);
		end else begin
			is_hex = 1'b0;
		end
		is_blank = (byte_s1 == hcbd_pkg::CH_SP) || (byte_s1 == hcbd_pkg::CH_TAB);
	end

	// size accumulate, saturating at all ones
	always_comb begin
		acc_wide = {left_q, nib};
		if (acc_wide[hcbd_pkg::SIZE_W+3:hcbd_pkg::SIZE_W] != 4'd0) begin
			acc_sat = '1;
		end else begin
			acc_sat = acc_wide[hcbd_pkg::SIZE_W-1:0];
		end
	end

	// outputs
	always_comb begin
		valid = 1'b0;
		ended = 1'b0;
		fault = 1'b0;
		if (!mode) begin
			valid = 1'b1;
		end else begin
			unique case (phase_q)
				hcbd_pkg::PH_LEAD: begin
					if (!is_blank && !is_hex) fault = 1'b1;
				end
				hcbd_pkg::PH_DIGITS: begin
					if (is_hex && count_q >= hcbd_pkg::CNT_W'(hcbd_pkg::MAX_SIZE_DIGITS))
						fault = 1'b1;
				end
				hcbd_pkg::PH_TAIL: ;
				hcbd_pkg::PH_TAIL_CR: begin
					if (byte_s1 == hcbd_pkg::CH_LF && left_q == '0) ended = 1'b1;
				end
				hcbd_pkg::PH_DATA: valid = 1'b1;
				hcbd_pkg::PH_WANT_CR: begin
					if (byte_s1 != hcbd_pkg::CH_CR) fault = 1'b1;
				end
				hcbd_pkg::PH_WANT_LF: begin
					if (byte_s1 != hcbd_pkg::CH_LF) fault = 1'b1;
				end
				hcbd_pkg::PH_ENDED: ended = 1'b1;
				hcbd_pkg::PH_PASS: valid = 1'b1;
				default: valid = 1'b1;
			endcase
			if (fault) valid = 1'b1;
		end
		res.data  = valid ? byte_s1 : 8'd0;
		res.valid = valid;
		res.ended = ended;
		res.fault = fault;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		left_d  = left_q;
		count_d = count_q;
		if (step && mode) begin
			unique case (phase_q)
				hcbd_pkg::PH_LEAD: begin
					if (is_hex) begin
						left_d  = hcbd_pkg::SIZE_W'(nib);
						count_d = hcbd_pkg::CNT_W'(1);
						phase_d = hcbd_pkg::PH_DIGITS;
					end
				end
				hcbd_pkg::PH_DIGITS: begin
					if (is_hex) begin
						left_d  = acc_sat;
						count_d = count_q + hcbd_pkg::CNT_W'(1);
					end else if (byte_s1 == hcbd_pkg::CH_CR) begin
						phase_d = hcbd_pkg::PH_TAIL_CR;
					end else begin
						phase_d = hcbd_pkg::PH_TAIL;
					end
				end
				hcbd_pkg::PH_TAIL: begin
					if (byte_s1 == hcbd_pkg::CH_CR) phase_d = hcbd_pkg::PH_TAIL_CR;
				end
				hcbd_pkg::PH_TAIL_CR: begin
					if (byte_s1 == hcbd_pkg::CH_LF) begin
						count_d = '0;
						phase_d = (left_q == '0) ? hcbd_pkg::PH_ENDED : hcbd_pkg::PH_DATA;
					end else if (byte_s1 != hcbd_pkg::CH_CR) begin
						phase_d = hcbd_pkg::PH_TAIL;
					end
				end
				hcbd_pkg::PH_DATA: begin
					left_d = left_q - hcbd_pkg::SIZE_W'(1);
					if (left_q == hcbd_pkg::SIZE_W'(1)) phase_d = hcbd_pkg::PH_WANT_CR;
				end
				hcbd_pkg::PH_WANT_CR: phase_d = hcbd_pkg::PH_WANT_LF;
				hcbd_pkg::PH_WANT_LF: phase_d = hcbd_pkg::PH_LEAD;
				hcbd_pkg::PH_ENDED: ;
				hcbd_pkg::PH_PASS: ;
				default: ;
			endcase
			if (fault) begin
				phase_d = hcbd_pkg::PH_PASS;
				left_d  = '0;
				count_d = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= hcbd_pkg::PH_LEAD;
			left_q  <= '0;
			count_q <= '0;
		end else begin
			phase_q <= phase_d;
			left_q  <= left_d;
			count_q <= count_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/hcbd_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_in_stage (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire logic [7:0] body_byte,
	input  wire logic       adv_ready,
	output logic            in_stall,
	output logic            valid_s1,
	output logic [7:0]      byte_s1
);

	// holds while a word sits here and the result side cannot take it
	assign in_stall = valid_s1 && !adv_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= body_byte;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/hcbd_out_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module hcbd_out_stage (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              valid_s1,
	input  wire hcbd_pkg::result_t res,
	input  wire logic              out_stall,
	output logic                   adv_ready,
	output logic                   out_valid,
	output hcbd_pkg::result_t      res_q
);

	logic out_valid_q;

	assign adv_ready = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_ready && valid_s1) begin
			res_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/http_chunked_body_decoder.sv
// Channel   Handshake                   Payload
// body in   in_valid / in_stall         body_byte[7:0]
// result    out_valid / out_stall       payload_byte[7:0], payload_valid,
//                                       stream_ended, framing_error
// config    cfg_we                      cfg_data (chunked_mode)
//
// One word in and one word out per clock when neither side stalls.
// Each word passes the input register, then the framing parser into the
// result register. The per-byte size accumulate / decrement sets the path.
// arst_n clears the parser to "awaiting first size line", chunked_mode to 1.
// out_stall reaches in_stall in the same cycle once both registers are full.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_we,
	input  wire logic       cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] body_byte,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      payload_byte,
	output logic            payload_valid,
	output logic            stream_ended,
	output logic            framing_error
);

	logic               chunked_mode_q;
	logic               valid_s1;
	logic [7:0]         byte_s1;
	logic               adv_ready;
	hcbd_pkg::result_t  res;
	hcbd_pkg::result_t  res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunked_mode_q <= 1'b1;
		end else if (cfg_we) begin
			chunked_mode_q <= cfg_data;
		end
	end

	hcbd_in_stage u_in (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.body_byte (body_byte),
		.adv_ready (adv_ready),
		.in_stall  (in_stall),
		.valid_s1  (valid_s1),
		.byte_s1   (byte_s1)
	);

	hcbd_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (valid_s1 && adv_ready),
		.mode    (chunked_mode_q),
		.byte_s1 (byte_s1),
		.res     (res)
	);

	hcbd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s1  (valid_s1),
		.res       (res),
		.out_stall (out_stall),
		.adv_ready (adv_ready),
		.out_valid (out_valid),
		.res_q     (res_q)
	);

	assign payload_byte  = res_q.data;
	assign payload_valid = res_q.valid;
	assign stream_ended  = res_q.ended;
	assign framing_error = res_q.fault;

endmodule

`default_nettype wire

// File: rtl/core/hcbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "http_chunked_body_decoder_assert.svh"

module hcbd_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_stall,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] payload_byte,
	input wire logic       payload_valid,
	input wire logic       stream_ended,
	input wire logic       framing_error
);

	// a stalled result word stays presented
	`HCBD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid, "result word dropped under stall")

	// input backs up only when the result side is full and stalled
	`HCBD_ASSERT_NOW(a_stall_cause, clk, arst_n, in_stall, out_valid && out_stall, "in_stall without a stalled result")

	// discarded bytes read as zero
	`HCBD_ASSERT_NOW(a_zero_fill, clk, arst_n, out_valid && !payload_valid, payload_byte == 8'd0, "non-payload word carries data")

	// the fault byte is passed on and cannot coincide with end of stream
	`HCBD_ASSERT_NOW(a_fault_word, clk, arst_n, out_valid && framing_error, payload_valid && !stream_ended, "bad flags on fault word")

endmodule

bind http_chunked_body_decoder hcbd_checker u_chk (.*);

`default_nettype wire
